/* src/windowed_frame_rate_meter_defines.svh */
// assertion macros for the windowed frame rate meter checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef WINDOWED_FRAME_RATE_METER_DEFINES_SVH
`define WINDOWED_FRAME_RATE_METER_DEFINES_SVH

// antecedent in this cycle, consequent in the next
`define WFRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wfrm check failed");

// antecedent and consequent in the same cycle
`define WFRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wfrm check failed");

`endif

/* src/wfrm_pkg.sv */
// shared types and constants of the windowed frame rate meter
// no dependencies
package wfrm_pkg;

  localparam int TS_W      = 48;
  localparam int Q_W       = 32;
  localparam int GAP_W     = 24;
  localparam int MIN_W     = 8;
  localparam int MAXS_W    = 7;
  localparam int REFRESH_W = 20;
  localparam int MODE_W    = 2;

  // multiply-divide unit sizing
  localparam int MUL_B_W  = 20;
  localparam int FRAC_W   = 16;
  localparam int NUM_W    = TS_W + MUL_B_W + FRAC_W;
  localparam int MD_CNT_W = $clog2(NUM_W + 1);

  localparam logic [MUL_B_W-1:0] US_PER_S = 20'd1000000;
  localparam logic [MUL_B_W-1:0] UNITY    = 20'd1;
  localparam logic [TS_W-1:0]    NS_PER_S = 48'd1000000000;

  localparam int QUEUE_DEPTH = 2;

  // input modes
  localparam logic [MODE_W-1:0] MODE_SYS    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GAME   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // register indexes
  localparam logic [2:0] REG_GAP_LIMIT = 3'd0;
  localparam logic [2:0] REG_SYS_MIN   = 3'd1;
  localparam logic [2:0] REG_GAME_MIN  = 3'd2;
  localparam logic [2:0] REG_SYS_MAX   = 3'd3;
  localparam logic [2:0] REG_GAME_MAX  = 3'd4;
  localparam logic [2:0] REG_REFRESH   = 3'd5;

  // report jobs on the shared divider
  localparam logic [1:0] JOB_SYS   = 2'd0;
  localparam logic [1:0] JOB_GAME  = 2'd1;
  localparam logic [1:0] JOB_SPEED = 2'd2;
  localparam logic [1:0] JOB_SCALE = 2'd3;

  typedef enum logic [1:0] {
    KIND_SYS,
    KIND_GAME,
    KIND_REPORT
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [TS_W-1:0] wall;
    logic [TS_W-1:0] guest;
  } item_t;

  typedef struct packed {
    logic [GAP_W-1:0]     gap_limit;
    logic [MIN_W-1:0]     sys_min;
    logic [MIN_W-1:0]     game_min;
    logic [MAXS_W-1:0]    sys_max;
    logic [MAXS_W-1:0]    game_max;
    logic [REFRESH_W-1:0] refresh;
  } cfg_t;

  typedef struct packed {
    logic [Q_W-1:0] scale;
    logic [Q_W-1:0] speed;
    logic [Q_W-1:0] game_rate;
    logic [Q_W-1:0] sys_fps;
  } report_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SYS,
    ST_REP_N,
    ST_REP_O,
    ST_REP_G,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

endpackage

/* src/wfrm_front.sv */
// front end: accepts stream items and classifies them by mode
// depends on wfrm_pkg
module wfrm_front import wfrm_pkg::*; (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [2*TS_W-1:0] s_axis_tdata,   // wall_us, guest_us
  input  logic [MODE_W-1:0] s_axis_tuser,   // mode
  input  logic              full_i,
  output logic              push_o,
  output item_t             item_o
);

  logic keep;

  assign s_axis_tready = !full_i;

  always_comb begin
    keep         = 1'b1;
    item_o.kind  = KIND_SYS;
    item_o.wall  = s_axis_tdata[TS_W-1:0];
    item_o.guest = s_axis_tdata[2*TS_W-1:TS_W];
    unique case (s_axis_tuser)
      MODE_SYS:    item_o.kind = KIND_SYS;
      MODE_GAME:   item_o.kind = KIND_GAME;
      MODE_REPORT: item_o.kind = KIND_REPORT;
      default:     keep = 1'b0;   // unused mode is dropped here
    endcase
  end

  assign push_o = s_axis_tvalid && !full_i && keep;

endmodule

/* src/wfrm_queue.sv */
// short queue of classified items between front and back
// depends on wfrm_pkg
module wfrm_queue import wfrm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  item_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               do_push, do_pop;

  assign full_o  = fill_q == FILL_W'(QUEUE_DEPTH);
  assign valid_o = fill_q != '0;
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* src/wfrm_muldiv.sv */
// shared multiply-divide unit: floor(a * b * 2^16 / d), saturated to 32 bits
// shift-add multiply then restoring division, one bit a cycle; depends on wfrm_pkg
module wfrm_muldiv import wfrm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TS_W-1:0]    a_i,
  input  logic [MUL_B_W-1:0] b_i,
  input  logic [TS_W-1:0]    d_i,
  output logic               done_o,
  output logic [Q_W-1:0]     q_o
);

  md_state_e             state_q, state_d;
  logic [MD_CNT_W-1:0]   cnt_q;
  logic                  done_q;
  logic [NUM_W-1:0]      acc_q, a_sh_q;
  logic [MUL_B_W-1:0]    b_q;
  logic [TS_W-1:0]       d_q, rem_q, rem_next;
  logic [Q_W:0]          quo_q, quo_next;
  logic [Q_W-1:0]        res_q;
  logic [TS_W:0]         rem_sh, rem_sub;
  logic                  ge;

  assign rem_sh   = {rem_q, acc_q[NUM_W-1]};
  assign ge       = rem_sh >= {1'b0, d_q};
  assign rem_sub  = rem_sh - {1'b0, d_q};
  assign rem_next = ge ? rem_sub[TS_W-1:0] : rem_sh[TS_W-1:0];
  assign quo_next = {quo_q[Q_W-1:0], ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (start_i && d_i != '0) state_d = MD_MUL;
      MD_MUL:  if (cnt_q == MD_CNT_W'(1)) state_d = MD_DIV;
      MD_DIV:  if (quo_next[Q_W] || cnt_q == MD_CNT_W'(1)) state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        MD_IDLE: begin
          cnt_q <= MD_CNT_W'(MUL_B_W);
          if (start_i && d_i == '0) done_q <= 1'b1;
        end
        MD_MUL: begin
          cnt_q <= (cnt_q == MD_CNT_W'(1)) ? MD_CNT_W'(NUM_W) : cnt_q - 1'b1;
        end
        MD_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (quo_next[Q_W] || cnt_q == MD_CNT_W'(1)) done_q <= 1'b1;
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        acc_q  <= '0;
        a_sh_q <= NUM_W'(a_i) << FRAC_W;
        b_q    <= b_i;
        d_q    <= d_i;
        rem_q  <= '0;
        quo_q  <= '0;
        res_q  <= '0;
      end
      MD_MUL: begin
        if (b_q[0]) acc_q <= acc_q + a_sh_q;
        a_sh_q <= a_sh_q << 1;
        b_q    <= b_q >> 1;
      end
      MD_DIV: begin
        acc_q <= acc_q << 1;
        rem_q <= rem_next;
        quo_q <= quo_next;
        // quotient past 32 bits saturates at once
        if (quo_next[Q_W]) begin
          res_q <= '1;
        end else begin
          res_q <= quo_next[Q_W-1:0];
        end
      end
      default: res_q <= res_q;
    endcase
  end

  assign done_o = done_q;
  assign q_o    = res_q;

endmodule

/* src/wfrm_back.sv */
// back end: sample rings, interval counters and report sequencer
// depends on wfrm_pkg and wfrm_muldiv
module wfrm_back import wfrm_pkg::*; #(
  parameter int RING_DEPTH = 128
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output report_t out_o
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int IDXP_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SPAN_W = (CNT_W > MAXS_W) ? CNT_W : MAXS_W;
  localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  // ring slot that lies 'back' entries before the newest
  function automatic logic [IDX_W-1:0] back_idx(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] back);
    logic [IDXP_W-1:0] t;
    t = {1'b0, head} + IDXP_W'(RING_DEPTH - 1) - {1'b0, back};
    if (t >= IDXP_W'(RING_DEPTH)) t = t - IDXP_W'(RING_DEPTH);
    return t[IDX_W-1:0];
  endfunction

  back_state_e state_q, state_d;

  logic [2*TS_W-1:0] sys_mem  [RING_DEPTH];
  logic [TS_W-1:0]   game_mem [RING_DEPTH];
  logic [2*TS_W-1:0] sys_rd_q;
  logic [TS_W-1:0]   game_rd_q;
  logic [IDX_W-1:0]  sys_raddr, game_raddr;
  logic              sys_we, game_we;

  item_t             item_q;
  logic [IDX_W-1:0]  sys_head_q, game_head_q;
  logic [CNT_W-1:0]  sys_count_q, game_count_q;
  logic [TS_W-1:0]   start_wall_q, start_guest_q;
  logic [Q_W-1:0]    sys_total_q, game_total_q;
  logic [TS_W-1:0]   last_end_q, last_len_q;

  logic [TS_W-1:0]   interval_q, gspan_q;
  logic [TS_W-1:0]   nw_q, ng_q, ow_q, og_q, gnw_q;
  logic [TS_W-1:0]   sys_dspan_q, win_gspan_q, game_dspan_q;
  logic              sys_win_q, game_win_q;
  logic [SPAN_W-1:0] sys_span, game_span;
  logic [CNT_W-1:0]  sys_cm1, game_cm1;
  logic              sys_enough, game_enough;
  logic [1:0]        job_q;
  logic [Q_W-1:0]    res_sys_q, res_game_q, res_speed_q, res_scale_q;
  report_t           out_q;
  logic              out_valid_q;
  logic              out_load;

  logic              md_start, md_done;
  logic [TS_W-1:0]   md_a, md_d;
  logic [MUL_B_W-1:0] md_b;
  logic [Q_W-1:0]    md_q;

  logic [TS_W-1:0]   prev_wall, gap;
  logic              gap_hit;

  assign sys_cm1   = sys_count_q - 1'b1;
  assign game_cm1  = game_count_q - 1'b1;
  assign sys_span  = (SPAN_W'(sys_cm1) < SPAN_W'(cfg_i.sys_max)) ?
                     SPAN_W'(sys_cm1) : SPAN_W'(cfg_i.sys_max);
  assign game_span = (SPAN_W'(game_cm1) < SPAN_W'(cfg_i.game_max)) ?
                     SPAN_W'(game_cm1) : SPAN_W'(cfg_i.game_max);
  assign sys_enough  = CMP_W'(sys_count_q) >= CMP_W'(2) &&
                       CMP_W'(sys_count_q) >= CMP_W'(cfg_i.sys_min);
  assign game_enough = CMP_W'(game_count_q) >= CMP_W'(2) &&
                       CMP_W'(game_count_q) >= CMP_W'(cfg_i.game_min);

  assign prev_wall = sys_rd_q[TS_W-1:0];
  assign gap       = item_q.wall - prev_wall;
  assign gap_hit   = sys_count_q != '0 && item_q.wall > prev_wall &&
                     gap > TS_W'(cfg_i.gap_limit);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (item_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        unique case (item_q.kind)
          KIND_SYS:    state_d = ST_SYS;
          KIND_REPORT: state_d = ST_REP_N;
          default:     state_d = ST_IDLE;
        endcase
      end
      ST_SYS:      state_d = ST_IDLE;
      ST_REP_N:    state_d = ST_REP_O;
      ST_REP_O:    state_d = ST_REP_G;
      ST_REP_G:    state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (md_done) state_d = (job_q == JOB_SCALE) ? ST_OUT : ST_DIV_GO;
      ST_OUT:      if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    item_pop_o = 1'b0;
    sys_we     = 1'b0;
    game_we    = 1'b0;
    md_start   = 1'b0;
    out_load   = 1'b0;
    sys_raddr  = back_idx(sys_head_q, '0);
    game_raddr = back_idx(game_head_q, '0);
    unique case (state_q)
      ST_IDLE:   item_pop_o = item_valid_i;
      ST_DECODE: game_we = item_q.kind == KIND_GAME;
      ST_SYS:    sys_we = 1'b1;
      ST_REP_N:  sys_raddr = back_idx(sys_head_q, sys_span[IDX_W-1:0]);
      ST_REP_O:  game_raddr = back_idx(game_head_q, game_span[IDX_W-1:0]);
      ST_DIV_GO: md_start = 1'b1;
      ST_OUT:    out_load = !out_valid_q || out_ready_i;
      default:   item_pop_o = 1'b0;
    endcase
  end

  // divider operands for the current job
  always_comb begin
    md_a = last_len_q;
    md_b = cfg_i.refresh;
    md_d = NS_PER_S;
    case (job_q)
      JOB_SYS: begin
        md_a = sys_win_q ? TS_W'(sys_span) : TS_W'(sys_total_q);
        md_b = US_PER_S;
        md_d = sys_win_q ? sys_dspan_q : interval_q;
      end
      JOB_GAME: begin
        md_a = game_win_q ? TS_W'(game_span) : TS_W'(game_total_q);
        md_b = US_PER_S;
        md_d = game_win_q ? game_dspan_q : interval_q;
      end
      JOB_SPEED: begin
        md_a = sys_win_q ? win_gspan_q : gspan_q;
        md_b = UNITY;
        md_d = sys_win_q ? sys_dspan_q : interval_q;
      end
      default: md_a = last_len_q;
    endcase
  end

  wfrm_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  // sample rings
  always_ff @(posedge clk_i) begin
    if (sys_we) sys_mem[sys_head_q] <= {item_q.guest, item_q.wall};
    sys_rd_q <= sys_mem[sys_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (game_we) game_mem[game_head_q] <= item_q.wall;
    game_rd_q <= game_mem[game_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sys_head_q    <= '0;
      game_head_q   <= '0;
      sys_count_q   <= '0;
      game_count_q  <= '0;
      start_wall_q  <= '0;
      start_guest_q <= '0;
      sys_total_q   <= '0;
      game_total_q  <= '0;
      last_end_q    <= '0;
      last_len_q    <= '0;
      job_q         <= JOB_SYS;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (game_we) begin
        game_head_q <= (game_head_q == IDX_W'(RING_DEPTH - 1)) ? '0 : game_head_q + 1'b1;
        if (game_count_q != CNT_W'(RING_DEPTH)) game_count_q <= game_count_q + 1'b1;
        if (game_total_q != '1) game_total_q <= game_total_q + 1'b1;
      end
      if (sys_we) begin
        last_len_q  <= (item_q.wall >= last_end_q) ? item_q.wall - last_end_q : '0;
        last_end_q  <= item_q.wall;
        if (sys_total_q != '1) sys_total_q <= sys_total_q + 1'b1;
        sys_head_q  <= (sys_head_q == IDX_W'(RING_DEPTH - 1)) ? '0 : sys_head_q + 1'b1;
        if (gap_hit) begin
          // long pause: the system window restarts with this sample, the game window empties
          sys_count_q  <= CNT_W'(1);
          game_count_q <= '0;
        end else if (sys_count_q != CNT_W'(RING_DEPTH)) begin
          sys_count_q <= sys_count_q + 1'b1;
        end
      end
      if (state_q == ST_REP_G) job_q <= JOB_SYS;
      if (state_q == ST_DIV_WAIT && md_done) job_q <= job_q + 1'b1;
      if (out_load) begin
        start_wall_q  <= item_q.wall;
        start_guest_q <= item_q.guest;
        sys_total_q   <= '0;
        game_total_q  <= '0;
      end
    end
  end

  // report datapath
  always_ff @(posedge clk_i) begin
    if (item_pop_o) item_q <= item_i;
    case (state_q)
      ST_DECODE: begin
        interval_q <= (item_q.wall > start_wall_q) ? item_q.wall - start_wall_q : '0;
        gspan_q    <= (item_q.guest > start_guest_q) ? item_q.guest - start_guest_q : '0;
      end
      ST_REP_N: begin
        nw_q <= sys_rd_q[TS_W-1:0];
        ng_q <= sys_rd_q[2*TS_W-1:TS_W];
      end
      ST_REP_O: begin
        ow_q  <= sys_rd_q[TS_W-1:0];
        og_q  <= sys_rd_q[2*TS_W-1:TS_W];
        gnw_q <= game_rd_q;
      end
      ST_REP_G: begin
        sys_win_q    <= sys_enough && nw_q > ow_q;
        game_win_q   <= game_enough && gnw_q > game_rd_q;
        sys_dspan_q  <= nw_q - ow_q;
        game_dspan_q <= gnw_q - game_rd_q;
        win_gspan_q  <= (ng_q > og_q) ? ng_q - og_q : '0;
      end
      ST_DIV_WAIT: begin
        if (md_done) begin
          case (job_q)
            JOB_SYS:   res_sys_q   <= md_q;
            JOB_GAME:  res_game_q  <= md_q;
            JOB_SPEED: res_speed_q <= md_q;
            default:   res_scale_q <= md_q;
          endcase
        end
      end
      default: interval_q <= interval_q;
    endcase
    // a waiting result keeps all four figures until it is taken
    if (out_load) begin
      out_q.sys_fps   <= res_sys_q;
      out_q.game_rate <= res_game_q;
      out_q.speed     <= res_speed_q;
      out_q.scale     <= res_scale_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* src/windowed_frame_rate_meter.sv */
// top level of the windowed frame rate meter: register port, front, queue, back
// depends on wfrm_pkg, wfrm_front, wfrm_queue, wfrm_back
//
//  channel  | direction | handshake              | content
//  s_axis   | in        | tvalid / tready        | tuser mode, tdata wall_us, guest_us
//  m_axis   | out       | tvalid / tready        | tdata the four q16.16 figures
//  apb      | in        | psel, penable, pready  | six registers at byte address 4*i
//
// in the back end a system frame passes the idle, decode and sys states, a game frame idle and decode
// a report makes four passes through the shared multiply-divide unit, each 20 multiply
// steps plus up to 84 divide steps plus handover
// the two-entry queue takes up to two items while the back end works or the result waits
// asynchronous active-low reset; rings hold no reset and are read only where written
module windowed_frame_rate_meter import wfrm_pkg::*; #(
  parameter int RING_DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*TS_W-1:0]   s_axis_tdata,   // wall_us [47:0], guest_us [95:48]
  input  logic [MODE_W-1:0]   s_axis_tuser,   // mode [1:0]
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [4*Q_W-1:0]    m_axis_tdata,   // system fps, game fps, speed,
                                              // frame scale from bit 0 up
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg_q;
  logic    cfg_wr;
  logic    push, full, q_valid, pop;
  item_t   front_item, q_item;
  report_t report;

  // register port: writes land in the access phase, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_limit <= GAP_W'(250000);
      cfg_q.sys_min   <= MIN_W'(16);
      cfg_q.game_min  <= MIN_W'(8);
      cfg_q.sys_max   <= MAXS_W'(90);
      cfg_q.game_max  <= MAXS_W'(45);
      cfg_q.refresh   <= REFRESH_W'(60000);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_GAP_LIMIT: cfg_q.gap_limit <= pwdata[GAP_W-1:0];
        REG_SYS_MIN:   cfg_q.sys_min   <= pwdata[MIN_W-1:0];
        REG_GAME_MIN:  cfg_q.game_min  <= pwdata[MIN_W-1:0];
        REG_SYS_MAX:   cfg_q.sys_max   <= pwdata[MAXS_W-1:0];
        REG_GAME_MAX:  cfg_q.game_max  <= pwdata[MAXS_W-1:0];
        REG_REFRESH:   cfg_q.refresh   <= pwdata[REFRESH_W-1:0];
        default:       cfg_q <= cfg_q;   // unmapped address, write dropped
      endcase
    end
  end

  // read back, unmapped addresses read zero
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_GAP_LIMIT: prdata = 32'(cfg_q.gap_limit);
      REG_SYS_MIN:   prdata = 32'(cfg_q.sys_min);
      REG_GAME_MIN:  prdata = 32'(cfg_q.game_min);
      REG_SYS_MAX:   prdata = 32'(cfg_q.sys_max);
      REG_GAME_MAX:  prdata = 32'(cfg_q.game_max);
      REG_REFRESH:   prdata = 32'(cfg_q.refresh);
      default:       prdata = '0;
    endcase
  end

  // front: classify, drop the unused mode
  wfrm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  // decoupling queue
  wfrm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // back: rings, counters, report sequencer and output register
  wfrm_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (report)
  );

  assign m_axis_tdata = report;

endmodule

/* src/wfrm_checker.sv */
// port-level checks for the windowed frame rate meter, bound to the top level
// depends on windowed_frame_rate_meter_defines.svh
`include "windowed_frame_rate_meter_defines.svh"

module wfrm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         pready
);

  // a waiting result keeps its figures
  `WFRM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // register port never inserts wait states
  `WFRM_ASSERT_NOW(a_no_wait, 1'b1, pready)

  // no result straight out of reset
  `WFRM_ASSERT_NOW(a_reset_quiet, $rose(rst_ni), !m_axis_tvalid)

endmodule

bind windowed_frame_rate_meter wfrm_checker u_checker (.*);

/* bench/tb.sv */
// self-checking bench for the windowed frame rate meter: stream in, q16.16 figures out
// depends on wfrm_pkg and windowed_frame_rate_meter
`timescale 1ns / 1ps

module tb;
  import wfrm_pkg::*;

  localparam longint unsigned LIMIT = 64'd6000000;
  localparam logic [47:0] MASK48 = 48'hFFFFFFFFFFFF;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [95:0]   s_axis_tdata = '0;
  logic [1:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [127:0]  m_axis_tdata;
  logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  windowed_frame_rate_meter dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state, mirrors the block after reset
  logic [47:0] sys_wall_q [128];
  logic [47:0] sys_guest_q [128];
  logic [47:0] game_wall_q [128];
  int unsigned sys_ptr, game_ptr, sys_fill, game_fill;
  logic [47:0] int_wall, int_guest, prev_end, prev_len;
  logic [31:0] sys_frames, gm_frame_cnt;
  logic [23:0] gap_lim;
  logic [7:0]  sys_min, game_min;
  logic [6:0]  sys_spans_max, game_spans_max;
  logic [19:0] refresh;

  report_t     expected_reports [$];
  int          mismatches = 0;
  longint unsigned cycles = 0;
  bit          sender_busy_idle = 1'b1;   // random gaps on the input side
  bit          sink_idle = 1'b1;          // random stalls on the result side
  int          hold_cycles = 0;           // long hold-off of the result side
  logic [47:0] wall_now, emu_now;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // floor(a*b/d) saturated at 32 bits, zero for a zero divisor
  function automatic logic [31:0] scaled_quotient(input logic [63:0] a, input logic [63:0] b,
                                                  input logic [63:0] d);
    logic [127:0] q;
    if (d == 0) return 32'd0;
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
    return (q > 128'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
  endfunction

  function automatic int unsigned back_slot(input int unsigned head, input int unsigned back);
    return (head + 256 - 1 - back) % 128;
  endfunction

  task automatic predict_reset();
    sys_ptr = 0; game_ptr = 0; sys_fill = 0; game_fill = 0;
    int_wall = 0; int_guest = 0; prev_end = 0; prev_len = 0;
    sys_frames = 0; gm_frame_cnt = 0;
    gap_lim = 24'd250000; sys_min = 8'd16; game_min = 8'd8;
    sys_spans_max = 7'd90; game_spans_max = 7'd45; refresh = 20'd60000;
  endtask

  task automatic predict_item(input logic [1:0] mode, input logic [47:0] wall,
                              input logic [47:0] guest);
    report_t r;
    logic [47:0] ispan, gspan, nw, ow, ng, og;
    int unsigned spans, ni, oi;
    if (mode == MODE_SYS) begin
      prev_len = (wall >= prev_end) ? wall - prev_end : 48'd0;
      prev_end = wall;
      if (sys_frames != 32'hFFFFFFFF) sys_frames++;
      if (sys_fill > 0) begin
        ow = sys_wall_q[back_slot(sys_ptr, 0)];
        if (wall > ow && wall - ow > {24'd0, gap_lim}) begin
          sys_fill = 0;
          game_fill = 0;
        end
      end
      sys_wall_q[sys_ptr] = wall;
      sys_guest_q[sys_ptr] = guest;
      sys_ptr = (sys_ptr + 1) % 128;
      if (sys_fill < 128) sys_fill++;
    end else if (mode == MODE_GAME) begin
      if (gm_frame_cnt != 32'hFFFFFFFF) gm_frame_cnt++;
      game_wall_q[game_ptr] = wall;
      game_ptr = (game_ptr + 1) % 128;
      if (game_fill < 128) game_fill++;
    end else if (mode == MODE_REPORT) begin
      ispan = (wall > int_wall) ? wall - int_wall : 48'd0;
      gspan = (guest > int_guest) ? guest - int_guest : 48'd0;
      r.sys_fps = scaled_quotient(64'(sys_frames), 64'd65536000000, 64'(ispan));
      r.game_rate = scaled_quotient(64'(gm_frame_cnt), 64'd65536000000, 64'(ispan));
      r.speed = scaled_quotient(64'(gspan), 64'd65536, 64'(ispan));
      if (sys_fill >= 2 && sys_fill >= sys_min) begin
        spans = (sys_fill - 1 < sys_spans_max) ? sys_fill - 1 : sys_spans_max;
        ni = back_slot(sys_ptr, 0);
        oi = back_slot(sys_ptr, spans);
        nw = sys_wall_q[ni]; ow = sys_wall_q[oi];
        if (nw > ow) begin
          ng = sys_guest_q[ni]; og = sys_guest_q[oi];
          r.sys_fps = scaled_quotient(64'(spans), 64'd65536000000, 64'(nw - ow));
          r.speed = scaled_quotient(64'((ng > og) ? ng - og : 48'd0), 64'd65536,
                                    64'(nw - ow));
        end
      end
      if (game_fill >= 2 && game_fill >= game_min) begin
        spans = (game_fill - 1 < game_spans_max) ? game_fill - 1 : game_spans_max;
        nw = game_wall_q[back_slot(game_ptr, 0)];
        ow = game_wall_q[back_slot(game_ptr, spans)];
        if (nw > ow) r.game_rate = scaled_quotient(64'(spans), 64'd65536000000, 64'(nw - ow));
      end
      r.scale = scaled_quotient(64'(prev_len), {44'd0, refresh} * 64'd65536,
                                64'd1000000000);
      int_wall = wall; int_guest = guest;
      sys_frames = 0; gm_frame_cnt = 0;
      expected_reports.push_back(r);
    end
  endtask

  // one request on the input stream, with an optional random gap first
  task automatic send_item(input logic [1:0] mode, input logic [47:0] wall,
                           input logic [47:0] guest);
    int gap;
    if (sender_busy_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {guest, wall};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(mode, wall, guest);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_GAP_LIMIT: gap_lim = value[23:0];
      REG_SYS_MIN:   sys_min = value[7:0];
      REG_GAME_MIN:  game_min = value[7:0];
      REG_SYS_MAX:   sys_spans_max = value[6:0];
      REG_GAME_MAX:  game_spans_max = value[6:0];
      default:       refresh = value[19:0];
    endcase
  endtask

  // idle wait: input released, all results in, then the back end latency of a report
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [23:0] gap, input logic [7:0] smin,
                            input logic [7:0] gmin, input logic [6:0] smax,
                            input logic [6:0] gmax, input logic [19:0] rate);
    drain();
    write_reg(REG_GAP_LIMIT, {8'd0, gap});
    write_reg(REG_SYS_MIN, {24'd0, smin});
    write_reg(REG_GAME_MIN, {24'd0, gmin});
    write_reg(REG_SYS_MAX, {25'd0, smax});
    write_reg(REG_GAME_MAX, {25'd0, gmax});
    write_reg(REG_REFRESH, {12'd0, rate});
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // extremes, every mode, the unused mode, backward and zero spans
  task automatic test_directed();
    send_item(MODE_REPORT, 48'd0, 48'd0);
    send_item(MODE_SYS, 48'd1000, 48'd900);
    send_item(MODE_GAME, 48'd1500, 48'd0);
    send_item(MODE_UNUSED, MASK48, MASK48);
    send_item(MODE_SYS, 48'd17000, 48'd17500);
    send_item(MODE_REPORT, 48'd20000, 48'd19000);
    send_item(MODE_REPORT, 48'd20000, 48'd19000);
    send_item(MODE_SYS, 48'd10, 48'd5);
    send_item(MODE_REPORT, 48'd5, 48'd1);
    send_item(MODE_SYS, MASK48, MASK48);
    send_item(MODE_GAME, MASK48, 48'd0);
    send_item(MODE_REPORT, MASK48, MASK48);
    send_item(MODE_SYS, 48'd1, 48'd0);
    send_item(MODE_SYS, 48'd2, 48'd0);
    send_item(MODE_REPORT, 48'd3, MASK48);
    send_item(MODE_SYS, 48'h800000000000, 48'h555555555555);
    send_item(MODE_REPORT, 48'h800000000001, 48'hAAAAAAAAAAAA);
  endtask

  // well-formed frame sequences with random pacing, plus noise and clock jumps
  task automatic test_random(input int items, input int max_step);
    logic [1:0] mode;
    int roll;
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_item(2'($urandom_range(0, 3)), rand48(), rand48());
      end else begin
        if (roll < 6) wall_now = wall_now + 48'($urandom_range(0, 3000000));
        else if (roll < 8) wall_now = wall_now - 48'($urandom_range(0, 50000));
        else wall_now = wall_now + 48'($urandom_range(0, max_step));
        emu_now = emu_now + 48'($urandom_range(0, max_step * 2));
        if (roll < 55) mode = MODE_SYS;
        else if (roll < 90) mode = MODE_GAME;
        else if (roll < 99) mode = MODE_REPORT;
        else mode = MODE_UNUSED;
        send_item(mode, wall_now & MASK48, emu_now & MASK48);
      end
    end
  endtask

  // result side stalls for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_cycles = 2000;
    for (int i = 0; i < 6; i++) begin
      wall_now += 48'd16667; emu_now += 48'd16000;
      send_item(MODE_REPORT, wall_now, emu_now);
      send_item(MODE_SYS, wall_now, emu_now);
    end
    drain();
  endtask

  initial begin
    predict_reset();
    wall_now = 48'd100000; emu_now = 48'd100000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_config(24'd0, 8'd2, 8'd2, 7'd1, 7'd1, 20'd1);
    test_random(250, 20000);
    set_config(24'hFFFFFF, 8'd128, 8'd128, 7'd127, 7'd127, 20'd1000000);
    test_random(400, 20000);
    set_config(24'd40000, 8'd0, 8'd255, 7'd0, 7'd127, 20'hFFFFF);
    test_random(250, 20000);
    set_config(24'd50000, 8'd4, 8'd3, 7'd30, 7'd20, 20'd144000);
    test_random(400, 17000);
    test_backpressure();
    set_config(24'd250000, 8'd16, 8'd8, 7'd90, 7'd45, 20'd60000);
    test_random(300, 17000);
    // final stretch with no idling on either side
    sender_busy_idle = 1'b0;
    sink_idle = 1'b0;
    test_random(250, 17000);
    drain();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stalls, and the long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= ~m_axis_tready;
    end else if (!sink_idle) begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = expected_reports.pop_front();
        if (got.sys_fps !== want.sys_fps) report_mismatch("system fps", got.sys_fps, want.sys_fps);
        if (got.game_rate !== want.game_rate)
          report_mismatch("game fps", got.game_rate, want.game_rate);
        if (got.speed !== want.speed) report_mismatch("speed", got.speed, want.speed);
        if (got.scale !== want.scale) report_mismatch("frame scale", got.scale, want.scale);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
